### hw/rtl/rrtt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrtt_pkg
// Shared types and constants of the round-robin task table unit.
// ----------------------------------------------------------------------------
package rrtt_pkg;

  localparam int TASK_SLOTS = 16;
  localparam int SLOT_W     = $clog2(TASK_SLOTS);
  localparam int PID_W      = 16;
  localparam int EXIT_W     = 8;
  localparam int ALIVE_W    = $clog2(TASK_SLOTS + 1);
  localparam int OP_W       = 3;
  localparam int STATUS_W   = 3;
  localparam logic [EXIT_W-1:0] EXIT_MASK = 8'hFF;

  typedef enum logic [OP_W-1:0] {
    OP_CREATE = 3'd0,
    OP_FORK   = 3'd1,
    OP_START  = 3'd2,
    OP_YIELD  = 3'd3,
    OP_EXIT   = 3'd4,
    OP_SWITCH = 3'd5,
    OP_WAIT   = 3'd6,
    OP_QUERY  = 3'd7
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK           = 3'd0,
    STS_NO_CHANGE    = 3'd1,
    STS_NO_FREE      = 3'd2,
    STS_NO_CURRENT   = 3'd3,
    STS_NONE_RUNNABLE = 3'd4,
    STS_NO_CHILD     = 3'd5,
    STS_CHILD_ALIVE  = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    SL_UNUSED  = 2'd0,
    SL_READY   = 2'd1,
    SL_RUNNING = 2'd2,
    SL_ZOMBIE  = 2'd3
  } slot_state_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_SCAN = 1'b1
  } fsm_t;

  typedef struct packed {
    logic              has_parent;
    logic [SLOT_W-1:0] parent;
    logic [PID_W-1:0]  pid;
  } info_t;

  typedef struct packed {
    logic is_free;
    logic is_ready;
    logic is_child;
    logic is_zombie;
  } match_t;

endpackage

### hw/rtl/round_robin_task_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_task_table_unit
// Task table with round-robin scheduling, fork/wait and pid allocation.
// ----------------------------------------------------------------------------
// One transaction at a time. An accepted event takes a setup step and then
// walks the table one slot per cycle until it finds its slot or has judged
// every slot; switch and no-current cases end on the first slot judged.
// The walk is what bounds the cost: slot states sit in flops, while pid,
// parent and exit byte sit in two record memories read one slot per cycle
// through a registered read (the read for the next slot is issued while
// the current one is judged). A result waits in the output register; the
// unit stalls its last scan cycle while the previous result is not taken.
// Slot pids, parents and exit bytes are undefined until a create or fork
// writes them.
// ----------------------------------------------------------------------------
module round_robin_task_table_unit
  import rrtt_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [OP_W-1:0]     in_operation,
  input  logic [SLOT_W-1:0]   in_target_slot,
  input  logic signed [PID_W-1:0] in_wanted_pid,
  input  logic [EXIT_W-1:0]   in_exit_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] out_result_code,
  output logic [PID_W-1:0]    out_result_pid,
  output logic [SLOT_W-1:0]   out_result_slot,
  output logic [2*EXIT_W-1:0] out_wait_status,
  output logic                out_child_has_exited,
  output logic                out_current_valid,
  output logic [SLOT_W-1:0]   out_current_slot,
  output logic [PID_W-1:0]    out_current_pid,
  output logic [ALIVE_W-1:0]  out_alive_count
);

  // Record memories
  info_t             info_mem [TASK_SLOTS];
  logic [EXIT_W-1:0] exit_mem [TASK_SLOTS];
  info_t             info_rd_r;
  logic [EXIT_W-1:0] exit_rd_r;
  logic [SLOT_W-1:0] rd_addr;
  logic              info_we;
  info_t             info_wdata;
  logic              exit_we;
  logic [SLOT_W-1:0] wr_addr;
  logic [EXIT_W-1:0] exit_wdata;

  // Control and scheduler state
  slot_state_t       slot_state_r [TASK_SLOTS];
  fsm_t              fsm_r, fsm_nxt;
  op_t               op_r, op_nxt;
  logic [SLOT_W-1:0] tgt_r, tgt_nxt;
  logic [PID_W-1:0]  want_r, want_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic [SLOT_W-1:0] cnt_r, cnt_nxt;
  logic              any_r, any_nxt;
  logic              run_valid_r, run_valid_nxt;
  logic [SLOT_W-1:0] run_slot_r, run_slot_nxt;
  logic [PID_W-1:0]  cur_pid_r, cur_pid_nxt;
  logic [PID_W-1:0]  next_pid_r, next_pid_nxt;
  logic [ALIVE_W-1:0] alive_r, alive_nxt;

  // Output register
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_code_r, out_code_nxt;
  logic [PID_W-1:0]    out_pid_r, out_pid_nxt;
  logic [SLOT_W-1:0]   out_slot_r, out_slot_nxt;
  logic [2*EXIT_W-1:0] out_wst_r, out_wst_nxt;
  logic                out_hx_r, out_hx_nxt;
  logic                out_cv_r, out_cv_nxt;
  logic [SLOT_W-1:0]   out_cs_r, out_cs_nxt;
  logic [PID_W-1:0]    out_cp_r, out_cp_nxt;
  logic [ALIVE_W-1:0]  out_alive_r, out_alive_nxt;

  // Two slot-state write ports; port b lands after port a
  logic              wa_en, wb_en;
  logic [SLOT_W-1:0] wa_slot, wb_slot;
  slot_state_t       wa_val, wb_val, old_b;

  match_t            match;
  logic              in_fire, out_free, last, done, need_cur;
  logic [SLOT_W-1:0] idx_inc, run_inc;

  rrtt_slot_match u_match (
    .slot_state (slot_state_r[idx_r]),
    .info       (info_rd_r),
    .want_pid   (want_r),
    .run_slot   (run_slot_r),
    .match      (match)
  );

  function automatic logic [SLOT_W-1:0] wrap_inc(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    r = (s == SLOT_W'(TASK_SLOTS - 1)) ? '0 : s + 1'b1;
    return r;
  endfunction

  function automatic logic is_live(input slot_state_t s);
    logic r;
    r = (s == SL_READY) || (s == SL_RUNNING);
    return r;
  endfunction

  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign idx_inc  = wrap_inc(idx_r);
  assign run_inc  = wrap_inc(run_slot_r);
  assign last     = (cnt_r == SLOT_W'(TASK_SLOTS - 1));
  assign need_cur = (op_r == OP_YIELD) || (op_r == OP_EXIT) ||
                    (op_r == OP_WAIT) || (op_r == OP_QUERY);

  always_comb begin
    fsm_nxt       = fsm_r;
    op_nxt        = op_r;
    tgt_nxt       = tgt_r;
    want_nxt      = want_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    any_nxt       = any_r;
    run_valid_nxt = run_valid_r;
    run_slot_nxt  = run_slot_r;
    cur_pid_nxt   = cur_pid_r;
    next_pid_nxt  = next_pid_r;
    in_stall      = (fsm_r != FSM_IDLE);
    rd_addr       = idx_r;
    info_we       = 1'b0;
    info_wdata    = '0;
    exit_we       = 1'b0;
    exit_wdata    = '0;
    wr_addr       = idx_r;
    wa_en = 1'b0; wa_slot = run_slot_r; wa_val = SL_UNUSED;
    wb_en = 1'b0; wb_slot = idx_r;      wb_val = SL_UNUSED;
    done            = 1'b0;
    out_code_nxt    = STS_OK;
    out_pid_nxt     = '0;
    out_slot_nxt    = '0;
    out_wst_nxt     = '0;
    out_hx_nxt      = 1'b0;
    out_valid_nxt   = out_valid_r && out_stall;

    unique case (fsm_r)
      FSM_IDLE: begin
        // Latch the event and point the record read at the first slot
        op_nxt   = op_t'(in_operation);
        tgt_nxt  = in_target_slot;
        if (in_wanted_pid[PID_W-1]) begin
          want_nxt = (in_wanted_pid == '1) ? '0 : PID_W'(-in_wanted_pid);
        end else begin
          want_nxt = in_wanted_pid;
        end
        cnt_nxt  = '0;
        any_nxt  = 1'b0;
        case (op_t'(in_operation))
          OP_YIELD, OP_EXIT: idx_nxt = run_inc;
          OP_SWITCH:         idx_nxt = in_target_slot;
          default:           idx_nxt = '0;
        endcase
        rd_addr = idx_nxt;
        if (in_fire) begin
          fsm_nxt = FSM_SCAN;
          // Exit retires the current task up front; the scan then finds a successor
          if ((op_t'(in_operation) == OP_EXIT) && run_valid_r) begin
            wa_en      = 1'b1;
            wa_val     = SL_ZOMBIE;
            exit_we    = 1'b1;
            wr_addr    = run_slot_r;
            exit_wdata = in_exit_value & EXIT_MASK;
          end
        end
      end

      FSM_SCAN: begin
        if (need_cur && !run_valid_r) begin
          done         = 1'b1;
          out_code_nxt = STS_NO_CURRENT;
        end else begin
          case (op_r)
            OP_CREATE, OP_FORK: begin
              if (match.is_free) begin
                done         = 1'b1;
                out_pid_nxt  = next_pid_r;
                out_slot_nxt = idx_r;
              end else if (last) begin
                done         = 1'b1;
                out_code_nxt = STS_NO_FREE;
              end
            end
            OP_START, OP_EXIT: begin
              if (match.is_ready) begin
                done         = 1'b1;
                out_pid_nxt  = info_rd_r.pid;
                out_slot_nxt = idx_r;
              end else if (last) begin
                done         = 1'b1;
                out_code_nxt = STS_NONE_RUNNABLE;
              end
            end
            OP_YIELD: begin
              if (match.is_ready && (idx_r != run_slot_r)) begin
                done         = 1'b1;
                out_pid_nxt  = info_rd_r.pid;
                out_slot_nxt = idx_r;
              end else if (match.is_ready || last) begin
                done         = 1'b1;
                out_code_nxt = STS_NO_CHANGE;
              end
            end
            OP_SWITCH: begin
              done         = 1'b1;
              out_pid_nxt  = info_rd_r.pid;
              out_slot_nxt = idx_r;
            end
            OP_WAIT: begin
              if (match.is_child && match.is_zombie) begin
                done         = 1'b1;
                out_pid_nxt  = info_rd_r.pid;
                out_slot_nxt = idx_r;
                out_wst_nxt  = {exit_rd_r & EXIT_MASK, EXIT_W'(0)};
              end else if (last) begin
                done         = 1'b1;
                out_code_nxt = (any_r || match.is_child) ? STS_CHILD_ALIVE
                                                         : STS_NO_CHILD;
              end
            end
            default: begin
              if (match.is_child) begin
                done         = 1'b1;
                out_pid_nxt  = info_rd_r.pid;
                out_slot_nxt = idx_r;
                out_hx_nxt   = match.is_zombie;
              end else if (last) begin
                done         = 1'b1;
                out_code_nxt = STS_NO_CHILD;
              end
            end
          endcase
        end

        if (!done) begin
          // Advance to the next slot; issue its record read now
          idx_nxt = idx_inc;
          cnt_nxt = cnt_r + 1'b1;
          any_nxt = any_r || (op_r == OP_WAIT && match.is_child);
          rd_addr = idx_inc;
        end else if (out_free) begin
          fsm_nxt       = FSM_IDLE;
          out_valid_nxt = 1'b1;
          if (out_code_nxt == STS_OK) begin
            case (op_r)
              OP_CREATE, OP_FORK: begin
                info_we               = 1'b1;
                info_wdata.pid        = next_pid_r;
                info_wdata.has_parent = (op_r == OP_FORK);
                info_wdata.parent     = (op_r == OP_FORK) ? tgt_r : '0;
                exit_we               = 1'b1;
                wb_en                 = 1'b1;
                wb_val                = SL_READY;
                next_pid_nxt = (next_pid_r == '1) ? PID_W'(1) : next_pid_r + 1'b1;
              end
              OP_START, OP_YIELD, OP_EXIT, OP_SWITCH: begin
                if ((op_r == OP_YIELD) ||
                    ((op_r == OP_SWITCH) && run_valid_r &&
                     (slot_state_r[run_slot_r] == SL_RUNNING))) begin
                  wa_en  = 1'b1;
                  wa_val = SL_READY;
                end
                wb_en         = 1'b1;
                wb_val        = SL_RUNNING;
                run_valid_nxt = 1'b1;
                run_slot_nxt  = idx_r;
                cur_pid_nxt   = info_rd_r.pid;
              end
              OP_WAIT: begin
                wb_en  = 1'b1;
                wb_val = SL_UNUSED;
              end
              default: ;
            endcase
          end else if ((op_r == OP_EXIT) && (out_code_nxt == STS_NONE_RUNNABLE)) begin
            // Nothing left to run
            run_valid_nxt = 1'b0;
            run_slot_nxt  = '0;
            cur_pid_nxt   = '0;
          end
        end else begin
          // Result register busy: hold this slot and its read data
          done    = 1'b0;
          rd_addr = idx_r;
        end
      end

      default: fsm_nxt = FSM_IDLE;
    endcase

    // Live count follows the slot-state writes
    alive_nxt = alive_r;
    if (wa_en) begin
      alive_nxt = alive_nxt - ALIVE_W'(is_live(slot_state_r[wa_slot]))
                            + ALIVE_W'(is_live(wa_val));
    end
    old_b = (wa_en && (wa_slot == wb_slot)) ? wa_val : slot_state_r[wb_slot];
    if (wb_en) begin
      alive_nxt = alive_nxt - ALIVE_W'(is_live(old_b)) + ALIVE_W'(is_live(wb_val));
    end

    out_cv_nxt    = run_valid_nxt;
    out_cs_nxt    = run_valid_nxt ? run_slot_nxt : '0;
    out_cp_nxt    = run_valid_nxt ? cur_pid_nxt : '0;
    out_alive_nxt = alive_nxt;
  end

  // Memories: one write and one registered read per cycle each
  always_ff @(posedge clk) begin
    if (info_we) begin
      info_mem[wr_addr] <= info_wdata;
    end
    if (exit_we) begin
      exit_mem[wr_addr] <= exit_wdata;
    end
    info_rd_r <= info_mem[rd_addr];
    exit_rd_r <= exit_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r       <= FSM_IDLE;
      run_valid_r <= 1'b0;
      run_slot_r  <= '0;
      cur_pid_r   <= '0;
      next_pid_r  <= PID_W'(1);
      alive_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < TASK_SLOTS; i++) begin
        slot_state_r[i] <= SL_UNUSED;
      end
    end else begin
      fsm_r       <= fsm_nxt;
      run_valid_r <= run_valid_nxt;
      run_slot_r  <= run_slot_nxt;
      cur_pid_r   <= cur_pid_nxt;
      next_pid_r  <= next_pid_nxt;
      alive_r     <= alive_nxt;
      out_valid_r <= out_valid_nxt;
      // Port b wins when both ports hit the same slot
      if (wa_en && !(wb_en && (wb_slot == wa_slot))) begin
        slot_state_r[wa_slot] <= wa_val;
      end
      if (wb_en) begin
        slot_state_r[wb_slot] <= wb_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    tgt_r  <= tgt_nxt;
    want_r <= want_nxt;
    idx_r  <= idx_nxt;
    cnt_r  <= cnt_nxt;
    any_r  <= any_nxt;
    if (fsm_r == FSM_SCAN && done && out_free) begin
      out_code_r   <= out_code_nxt;
      out_pid_r    <= out_pid_nxt;
      out_slot_r   <= out_slot_nxt;
      out_wst_r    <= out_wst_nxt;
      out_hx_r     <= out_hx_nxt;
      out_cv_r     <= out_cv_nxt;
      out_cs_r     <= out_cs_nxt;
      out_cp_r     <= out_cp_nxt;
      out_alive_r  <= out_alive_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_result_code      = out_code_r;
  assign out_result_pid       = out_pid_r;
  assign out_result_slot      = out_slot_r;
  assign out_wait_status      = out_wst_r;
  assign out_child_has_exited = out_hx_r;
  assign out_current_valid    = out_cv_r;
  assign out_current_slot     = out_cs_r;
  assign out_current_pid      = out_cp_r;
  assign out_alive_count      = out_alive_r;

endmodule

### hw/rtl/rrtt_slot_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrtt_slot_match
// Classifies the slot under scan: free, ready, zombie, child of the current task.
// ----------------------------------------------------------------------------
module rrtt_slot_match
  import rrtt_pkg::*;
(
  input  slot_state_t       slot_state,
  input  info_t             info,
  input  logic [PID_W-1:0]  want_pid,
  input  logic [SLOT_W-1:0] run_slot,
  output match_t            match
);

  always_comb begin
    match.is_free   = (slot_state == SL_UNUSED);
    match.is_ready  = (slot_state == SL_READY);
    match.is_zombie = (slot_state == SL_ZOMBIE);
    match.is_child  = (slot_state != SL_UNUSED) && info.has_parent &&
                      (info.parent == run_slot) &&
                      ((want_pid == '0) || (info.pid == want_pid));
  end

endmodule

### hw/rtl/rrtt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrtt_checker
// Port-level checks of the round-robin task table unit.
// ----------------------------------------------------------------------------
module rrtt_checker
  import rrtt_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [STATUS_W-1:0] out_result_code,
  input logic                out_current_valid,
  input logic [SLOT_W-1:0]   out_current_slot,
  input logic [PID_W-1:0]    out_current_pid
);

  // One transaction in flight: the unit is busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while previous transaction in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_code) &&
                               $stable(out_current_pid))
    else $error("stalled result changed");

  a_no_current: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_code == STS_NO_CURRENT) |-> !out_current_valid)
    else $error("no-current status with a running task");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_current_valid |-> (out_current_pid == '0) &&
                                        (out_current_slot == '0))
    else $error("current fields nonzero without a running task");

endmodule

bind round_robin_task_table_unit rrtt_checker u_rrtt_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_result_code   (out_result_code),
  .out_current_valid (out_current_valid),
  .out_current_slot  (out_current_slot),
  .out_current_pid   (out_current_pid)
);
